@@ rtl/bavg_pkg.sv @@
// bavg_pkg: shared widths, reset values, register indexes and state encoding of the block average decimator
// no dependencies; used by block_average_decimator and its testbench
`timescale 1ns / 1ps

package bavg_pkg;

    localparam int CHANNELS_DEF   = 13;
    localparam int VALUE_BITS_DEF = 32;

    localparam int GROUP_BITS = 11;
    localparam int COUNT_BITS = 25;

    localparam int CFG_IDX_BITS = 2;

    localparam logic [CFG_IDX_BITS-1:0] REG_GROUP_SIZE   = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_RECORD_COUNT = 2'd1;

    localparam logic [GROUP_BITS-1:0] GROUP_RESET = 11'd4;
    localparam logic [COUNT_BITS-1:0] COUNT_RESET = 25'd2;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_RD   = 4'b0010,
        S_DIV  = 4'b0100,
        S_OUT  = 4'b1000
    } t_state;

endpackage

@@ rtl/block_average_decimator.sv @@
// block_average_decimator: record bookkeeping, sum read-modify-write and output register
// pass-through request: held in S_OUT until the output register is free, then on o_valid
// averaged request: sum written in S_RD; one closing a group then goes via S_DIV and S_OUT
// o_stall is high outside S_IDLE; one-bit-per-cycle divider over the VALUE_BITS + 11 bit sum
// reset: synchronous; counters cleared, config back to defaults, sum store left as is
// depends on bavg_pkg, bavg_sum_ram, bavg_div
`timescale 1ns / 1ps

module block_average_decimator #(
    parameter int CHANNELS   = bavg_pkg::CHANNELS_DEF,
    parameter int VALUE_BITS = bavg_pkg::VALUE_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic signed [VALUE_BITS-1:0]        i_sample_value,
    input  logic                                i_record_end,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic signed [VALUE_BITS-1:0]        o_mean_value,
    output logic                                o_record_done,
    output logic                                o_dataset_done,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [bavg_pkg::CFG_IDX_BITS-1:0]   i_cfg_index,
    input  logic [bavg_pkg::COUNT_BITS-1:0]     i_cfg_data
);

    localparam int GB       = bavg_pkg::GROUP_BITS;
    localparam int CB       = bavg_pkg::COUNT_BITS;
    localparam int SUM_BITS = VALUE_BITS + GB;
    localparam int CH_BITS  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    // config
    logic [GB-1:0] r_group_size;
    logic [CB-1:0] r_record_count;

    // control state
    bavg_pkg::t_state r_state, n_state;
    logic [CH_BITS-1:0]  r_ch, n_ch;
    logic [CB-1:0]       r_rec, n_rec;
    logic [GB-1:0]       r_rig, n_rig;
    logic [GB-1:0]       r_eg, n_eg;
    logic [CHANNELS-1:0] r_mask, n_mask;
    logic                r_out_valid, n_out_valid;

    // request payload held while it is worked on
    logic signed [VALUE_BITS-1:0] r_v;
    logic [CH_BITS-1:0]           r_wch;
    logic                         r_fresh;
    logic [GB-1:0]                r_div;
    logic                         r_emit;
    logic                         r_rdone;
    logic                         r_ddone;
    logic [VALUE_BITS-1:0]        r_res;
    logic [VALUE_BITS-1:0]        r_mean;
    logic                         r_out_rdone;
    logic                         r_out_ddone;

    logic              w_accept;
    logic              w_last_ch;
    logic [CB-1:0]     w_rc_m1;
    logic              w_is_last;
    logic              w_is_middle;
    logic [GB-1:0]     w_gs;
    logic [CB-1:0]     w_remaining;
    logic [GB-1:0]     w_new_eg;
    logic [GB-1:0]     w_divisor;
    logic [GB:0]       w_rig_p1;
    logic              w_emit;
    logic              w_load_out;
    logic              w_we;
    logic [SUM_BITS-1:0] w_rdata;
    logic [SUM_BITS-1:0] w_sum;
    logic              w_div_start;
    logic              w_div_done;
    logic [VALUE_BITS-1:0] w_quotient;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_group_size   <= bavg_pkg::GROUP_RESET;
            r_record_count <= bavg_pkg::COUNT_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                bavg_pkg::REG_GROUP_SIZE:   r_group_size   <= i_cfg_data[GB-1:0];
                bavg_pkg::REG_RECORD_COUNT: r_record_count <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // record position and group sizing
    assign w_accept    = i_valid && !o_stall;
    assign o_stall     = (r_state != bavg_pkg::S_IDLE);
    assign w_last_ch   = i_record_end || (r_ch == CH_BITS'(CHANNELS - 1));
    assign w_rc_m1     = ((r_record_count < CB'(2)) ? CB'(2) : r_record_count) - CB'(1);
    assign w_is_last   = r_rec >= w_rc_m1;
    assign w_is_middle = (r_rec != '0) && !w_is_last;
    assign w_gs        = (r_group_size == '0) ? GB'(1) : r_group_size;
    assign w_remaining = w_rc_m1 - r_rec;

    always_comb begin
        w_new_eg = r_eg;
        if (r_rig == '0 && r_ch == '0) begin
            w_new_eg = (CB'(w_gs) >= w_remaining) ? w_remaining[GB-1:0] : w_gs;
        end
    end

    assign w_divisor = (w_new_eg == '0) ? GB'(1) : w_new_eg;
    assign w_rig_p1  = {1'b0, r_rig} + (GB + 1)'(1);
    assign w_emit    = w_is_middle && (w_rig_p1 >= {1'b0, w_divisor});

    assign w_load_out  = (r_state == bavg_pkg::S_OUT) && (!r_out_valid || !i_stall);
    assign w_we        = (r_state == bavg_pkg::S_RD);
    assign w_div_start = w_we && r_emit;
    assign w_sum       = (r_fresh ? '0 : w_rdata) + {{GB{r_v[VALUE_BITS-1]}}, r_v};

    always_comb begin
        n_state     = r_state;
        n_ch        = r_ch;
        n_rec       = r_rec;
        n_rig       = r_rig;
        n_eg        = r_eg;
        n_mask      = r_mask;
        n_out_valid = r_out_valid;
        if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            bavg_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_state = w_is_middle ? bavg_pkg::S_RD : bavg_pkg::S_OUT;
                    n_ch    = w_last_ch ? '0 : r_ch + CH_BITS'(1);
                    if (w_is_middle) begin
                        n_eg         = w_new_eg;
                        n_mask[r_ch] = 1'b1;
                        if (w_last_ch) begin
                            n_rig = w_emit ? '0 : w_rig_p1[GB-1:0];
                            if (w_emit) begin
                                n_mask = '0;
                            end
                        end
                    end
                    if (w_last_ch) begin
                        if (w_is_last) begin
                            n_rec  = '0;
                            n_rig  = '0;
                            n_eg   = '0;
                            n_mask = '0;
                        end else begin
                            n_rec = r_rec + CB'(1);
                        end
                    end
                end
            end
            bavg_pkg::S_RD: begin
                n_state = r_emit ? bavg_pkg::S_DIV : bavg_pkg::S_IDLE;
            end
            bavg_pkg::S_DIV: begin
                if (w_div_done) begin
                    n_state = bavg_pkg::S_OUT;
                end
            end
            bavg_pkg::S_OUT: begin
                if (w_load_out) begin
                    n_state     = bavg_pkg::S_IDLE;
                    n_out_valid = 1'b1;
                end
            end
            default: n_state = bavg_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= bavg_pkg::S_IDLE;
            r_ch        <= '0;
            r_rec       <= '0;
            r_rig       <= '0;
            r_eg        <= '0;
            r_mask      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_ch        <= n_ch;
            r_rec       <= n_rec;
            r_rig       <= n_rig;
            r_eg        <= n_eg;
            r_mask      <= n_mask;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_v     <= i_sample_value;
            r_wch   <= r_ch;
            r_fresh <= !r_mask[r_ch];
            r_div   <= w_divisor;
            r_emit  <= w_emit;
            r_rdone <= w_last_ch;
            r_ddone <= w_last_ch && w_is_last;
            r_res   <= i_sample_value;
        end else if (r_state == bavg_pkg::S_DIV && w_div_done) begin
            r_res   <= w_quotient;
        end
        if (w_load_out) begin
            r_mean      <= r_res;
            r_out_rdone <= r_rdone;
            r_out_ddone <= r_ddone;
        end
    end

    bavg_sum_ram #(
        .DEPTH     (CHANNELS),
        .WIDTH     (SUM_BITS),
        .ADDR_BITS (CH_BITS)
    ) u_sum_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_wch),
        .i_wdata (w_sum),
        .i_re    (w_accept),
        .i_raddr (r_ch),
        .o_rdata (w_rdata)
    );

    bavg_div #(
        .SUM_BITS (SUM_BITS),
        .DIV_BITS (GB),
        .OUT_BITS (VALUE_BITS)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_sum),
        .i_divisor  (r_div),
        .o_done     (w_div_done),
        .o_quotient (w_quotient)
    );

    assign o_valid        = r_out_valid;
    assign o_mean_value   = r_mean;
    assign o_record_done  = r_out_rdone;
    assign o_dataset_done = r_out_ddone;

    a_div_start_in_rd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_start |-> (r_state == bavg_pkg::S_RD))
        else $error("divider started outside read stage");

    a_div_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_state == bavg_pkg::S_DIV))
        else $error("divider finished outside divide stage");

    a_group_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_rig < r_eg) || (r_rig == '0))
        else $error("records in group beyond group size");

    a_dataset_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_last_ch && w_is_last) |=> (r_rec == '0 && r_mask == '0))
        else $error("dataset end did not restart bookkeeping");

    a_dataset_done_ends_record: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_dataset_done) |-> o_record_done)
        else $error("dataset end flagged inside a record");

endmodule

@@ rtl/bavg_sum_ram.sv @@
// bavg_sum_ram: per-channel sum store, one write and one registered read port
// depends on nothing
`timescale 1ns / 1ps

module bavg_sum_ram #(
    parameter int DEPTH = 13,
    parameter int WIDTH = 43,
    parameter int ADDR_BITS = 4
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [ADDR_BITS-1:0] i_waddr,
    input  logic [WIDTH-1:0]     i_wdata,
    input  logic                 i_re,
    input  logic [ADDR_BITS-1:0] i_raddr,
    output logic [WIDTH-1:0]     o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/bavg_div.sv @@
// bavg_div: signed by unsigned restoring divider, one quotient bit per cycle
// depends on nothing; quotient truncated toward zero and cut to the output width
`timescale 1ns / 1ps

module bavg_div #(
    parameter int SUM_BITS = 43,
    parameter int DIV_BITS = 11,
    parameter int OUT_BITS = 32
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic signed [SUM_BITS-1:0] i_dividend,
    input  logic        [DIV_BITS-1:0] i_divisor,
    output logic                       o_done,
    output logic        [OUT_BITS-1:0] o_quotient
);

    localparam int CNT_BITS = $clog2(SUM_BITS);

    logic                r_busy;
    logic                r_done;
    logic [CNT_BITS-1:0] r_cnt;
    logic [DIV_BITS-1:0] r_rem;
    logic [DIV_BITS-1:0] r_den;
    logic [SUM_BITS-1:0] r_quo;
    logic                r_neg;

    logic [DIV_BITS:0]   w_trial;
    logic [DIV_BITS:0]   w_diff;
    logic                w_ge;
    logic [OUT_BITS-1:0] w_qlow;

    assign w_trial = {r_rem, r_quo[SUM_BITS-1]};
    assign w_ge    = w_trial >= {1'b0, r_den};
    assign w_diff  = w_trial - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_BITS'(SUM_BITS - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_BITS'(1);
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath: magnitude in, shift-subtract, sign applied on the way out
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg <= i_dividend[SUM_BITS-1];
            r_quo <= i_dividend[SUM_BITS-1] ? SUM_BITS'(-i_dividend) : i_dividend;
            r_den <= i_divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[DIV_BITS-1:0] : w_trial[DIV_BITS-1:0];
            r_quo <= {r_quo[SUM_BITS-2:0], w_ge};
        end
    end

    assign w_qlow     = r_quo[OUT_BITS-1:0];
    assign o_quotient = r_neg ? (OUT_BITS'(0) - w_qlow) : w_qlow;
    assign o_done     = r_done;

endmodule

@@ verif/tb_block_average_decimator.sv @@
// tb_block_average_decimator: self-checking testbench for the block average decimator
// predicts every output request from its own model of the record and group bookkeeping
// depends on bavg_pkg and block_average_decimator
`timescale 1ns / 1ps

module tb_block_average_decimator;

    localparam int CHANNELS      = bavg_pkg::CHANNELS_DEF;
    localparam int VALUE_BITS    = bavg_pkg::VALUE_BITS_DEF;
    localparam int IDX_BITS      = bavg_pkg::CFG_IDX_BITS;
    localparam int GRP_BITS      = bavg_pkg::GROUP_BITS;
    localparam int CNT_BITS      = bavg_pkg::COUNT_BITS;
    localparam int SETTLE_CYCLES = 64;
    localparam int DRAIN_LIMIT   = 20000;
    localparam int LONG_HOLD     = 400;
    localparam int RANDOM_ITEMS  = 520;
    localparam int QUIET_ITEMS   = 80;

    localparam logic [IDX_BITS-1:0] REG_SPARE_A = 2'd2;
    localparam logic [IDX_BITS-1:0] REG_SPARE_B = 2'd3;

    localparam logic signed [VALUE_BITS-1:0] VALUE_MIN = {1'b1, {(VALUE_BITS-1){1'b0}}};
    localparam logic signed [VALUE_BITS-1:0] VALUE_MAX = {1'b0, {(VALUE_BITS-1){1'b1}}};

    typedef struct {
        logic signed [VALUE_BITS-1:0] mean_value;
        logic                         record_done;
        logic                         dataset_done;
    } t_mean_rec;

    logic                          i_clk          = 1'b0;
    logic                          i_rst_n        = 1'b0;
    logic                          i_valid        = 1'b0;
    logic                          o_stall;
    logic signed [VALUE_BITS-1:0]  i_sample_value = '0;
    logic                          i_record_end   = 1'b0;
    logic                          o_valid;
    logic                          i_stall        = 1'b0;
    logic signed [VALUE_BITS-1:0]  o_mean_value;
    logic                          o_record_done;
    logic                          o_dataset_done;
    logic                          i_cfg_valid    = 1'b0;
    logic                          o_cfg_ready;
    logic [IDX_BITS-1:0]           i_cfg_index    = '0;
    logic [CNT_BITS-1:0]           i_cfg_data     = '0;

    // predictor copy of the configuration and bookkeeping
    logic [GRP_BITS-1:0] cfg_group = bavg_pkg::GROUP_RESET;
    logic [CNT_BITS-1:0] cfg_count = bavg_pkg::COUNT_RESET;
    longint                acc_sum [16] = '{default: 0};
    int unsigned           chan_pos = 0;
    int unsigned           rec_pos  = 0;
    int unsigned           grp_fill = 0;
    int unsigned           grp_len  = 0;

    t_mean_rec   expected_means [$];
    int unsigned group_width     = CHANNELS;
    int unsigned failures        = 0;
    int unsigned samples_sent    = 0;
    int unsigned results_seen    = 0;
    int unsigned cfg_writes      = 0;
    int unsigned datasets_closed = 0;

    bit   tx_gaps    = 1'b1;
    logic rx_idling  = 1'b1;
    int   hold_reqs  = 0;
    int   hold_seen  = 0;
    int   hold_left  = 0;
    int   burst_left = 0;

    block_average_decimator #(
        .CHANNELS   (CHANNELS),
        .VALUE_BITS (VALUE_BITS)
    ) DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_sample_value (i_sample_value),
        .i_record_end   (i_record_end),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_mean_value   (o_mean_value),
        .o_record_done  (o_record_done),
        .o_dataset_done (o_dataset_done),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        #(5_000_000);
        $display("timeout: %0d results still awaited", expected_means.size());
        $display("Test completed with failures");
        $finish;
    end

    // receiver: random short stalls plus a long hold-off on request
    always @(negedge i_clk) begin
        if (hold_reqs != hold_seen) begin
            hold_seen <= hold_reqs;
            hold_left <= LONG_HOLD;
            i_stall   <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            i_stall   <= 1'b1;
        end else if (burst_left != 0) begin
            burst_left <= burst_left - 1;
            i_stall    <= 1'b1;
        end else if (rx_idling && $urandom_range(0, 5) == 0) begin
            burst_left <= int'($urandom_range(0, 7));
            i_stall    <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    task automatic report_failure(input string what);
        failures++;
        if (failures <= 10)
            $display("mismatch %0d: %s", failures, what);
    endtask

    always @(posedge i_clk) begin : check_result
        t_mean_rec want;
        if (i_rst_n && o_valid && !i_stall) begin
            results_seen++;
            if (expected_means.size() == 0) begin
                report_failure($sformatf("unexpected result mean %0d rd %0b dd %0b",
                                         o_mean_value, o_record_done, o_dataset_done));
            end else begin
                want = expected_means.pop_front();
                if (o_mean_value !== want.mean_value || o_record_done !== want.record_done ||
                    o_dataset_done !== want.dataset_done)
                    report_failure($sformatf(
                        "expected mean %0d rd %0b dd %0b, got mean %0d rd %0b dd %0b",
                        want.mean_value, want.record_done, want.dataset_done,
                        o_mean_value, o_record_done, o_dataset_done));
            end
        end
    end

    function automatic void apply_config(input logic [IDX_BITS-1:0] idx,
                                         input logic [CNT_BITS-1:0] data);
        if (idx == bavg_pkg::REG_GROUP_SIZE)
            cfg_group = data[GRP_BITS-1:0];
        else if (idx == bavg_pkg::REG_RECORD_COUNT)
            cfg_count = data;
    endfunction

    function automatic bit predict_mean(input logic signed [VALUE_BITS-1:0] v, input logic rend,
                                        output t_mean_rec r);
        int unsigned rc, gs, ch, remaining, divisor;
        bit          last_ch, last_rec, middle, produced;
        longint      q;
        rc       = (cfg_count < 2) ? 32'd2 : 32'(cfg_count);
        gs       = (cfg_group == 0) ? 32'd1 : 32'(cfg_group);
        ch       = chan_pos;
        last_ch  = rend || (ch >= CHANNELS - 1);
        last_rec = rec_pos >= rc - 1;
        middle   = (rec_pos != 0) && !last_rec;
        produced = 1'b0;
        r.mean_value   = '0;
        r.record_done  = 1'b0;
        r.dataset_done = 1'b0;
        if (!middle) begin
            r.mean_value   = v;
            r.record_done  = last_ch;
            r.dataset_done = last_ch && last_rec;
            produced       = 1'b1;
        end else begin
            if (grp_fill == 0 && ch == 0) begin
                remaining = rc - 1 - rec_pos;
                grp_len   = (gs >= remaining) ? remaining : gs;
            end
            divisor     = (grp_len != 0) ? grp_len : 1;
            acc_sum[ch] = acc_sum[ch] + longint'(v);
            if (grp_fill + 1 >= divisor) begin
                q             = acc_sum[ch] / longint'(divisor);
                r.mean_value  = q[VALUE_BITS-1:0];
                r.record_done = last_ch;
                produced      = 1'b1;
            end
        end
        if (last_ch) begin
            chan_pos = 0;
            if (middle) begin
                divisor = (grp_len != 0) ? grp_len : 1;
                grp_fill++;
                if (grp_fill >= divisor) begin
                    grp_fill = 0;
                    acc_sum  = '{default: 0};
                end
            end
            if (last_rec) begin
                rec_pos  = 0;
                grp_fill = 0;
                grp_len  = 0;
                acc_sum  = '{default: 0};
                datasets_closed++;
            end else begin
                rec_pos++;
            end
        end else begin
            chan_pos = ch + 1;
        end
        return produced;
    endfunction

    task automatic send_sample(input logic signed [VALUE_BITS-1:0] v, input logic rend);
        t_mean_rec r;
        if (tx_gaps && $urandom_range(0, 4) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge i_clk);
        end
        i_valid        <= 1'b1;
        i_sample_value <= v;
        i_record_end   <= rend;
        do @(posedge i_clk); while (o_stall);
        if (predict_mean(v, rend, r))
            expected_means.push_back(r);
        samples_sent++;
        @(negedge i_clk);
    endtask

    function automatic logic signed [VALUE_BITS-1:0] pick_value();
        case ($urandom_range(0, 7))
            0:       return VALUE_MIN;
            1:       return VALUE_MAX;
            2, 3:    return VALUE_BITS'($urandom_range(0, 4000)) - VALUE_BITS'(2000);
            default: return VALUE_BITS'($urandom);
        endcase
    endfunction

    function automatic int unsigned pick_len();
        return ($urandom_range(0, 9) < 6) ? CHANNELS : $urandom_range(1, CHANNELS - 1);
    endfunction

    function automatic logic [GRP_BITS-1:0] pick_group();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return 11'd1024;
            2:       return {GRP_BITS{1'b1}};
            3:       return GRP_BITS'($urandom_range(6, 40));
            default: return GRP_BITS'($urandom_range(1, 5));
        endcase
    endfunction

    function automatic logic [CNT_BITS-1:0] pick_count();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return CNT_BITS'(1);
            2:       return CNT_BITS'(2);
            3:       return CNT_BITS'($urandom_range(10, 24));
            default: return CNT_BITS'($urandom_range(3, 8));
        endcase
    endfunction

    // later records of a group carry no more channels than its first record
    task automatic send_record(input int unsigned want);
        int unsigned len, rc;
        bit          middle;
        rc     = (cfg_count < 2) ? 32'd2 : 32'(cfg_count);
        middle = (rec_pos != 0) && (rec_pos < rc - 1);
        len    = want;
        if (middle && grp_fill == 0)
            group_width = len;
        else if (middle && len > group_width)
            len = group_width;
        for (int unsigned k = 0; k < len; k++) begin
            logic rend;
            if (k + 1 != len)
                rend = 1'b0;
            else if (len == CHANNELS)
                rend = 1'($urandom_range(0, 1));
            else
                rend = 1'b1;
            send_sample(pick_value(), rend);
        end
    endtask

    task automatic finish_dataset();
        while (rec_pos != 0)
            send_record(pick_len());
    endtask

    task automatic settle();
        i_valid <= 1'b0;
        while (expected_means.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [IDX_BITS-1:0] idx,
                             input logic [CNT_BITS-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        apply_config(idx, data);
        cfg_writes++;
        @(negedge i_clk);
    endtask

    task automatic configure(input logic [GRP_BITS-1:0] gs, input logic [CNT_BITS-1:0] rc,
                             input bit spare);
        logic [CNT_BITS-GRP_BITS-1:0] junk;
        junk = (CNT_BITS-GRP_BITS)'($urandom);
        settle();
        write_reg(bavg_pkg::REG_GROUP_SIZE, {junk, gs});
        write_reg(bavg_pkg::REG_RECORD_COUNT, rc);
        if (spare) begin
            write_reg(REG_SPARE_A, CNT_BITS'($urandom));
            write_reg(REG_SPARE_B, CNT_BITS'($urandom));
        end
        i_cfg_valid <= 1'b0;
    endtask

    // reset values: two pass-through records
    task automatic test_after_reset();
        send_sample(VALUE_MIN, 1'b0);
        send_sample(VALUE_MAX, 1'b1);
        send_sample(-1, 1'b1);
    endtask

    // zero group size with a record count below two, then with a count of four
    task automatic test_degenerate_config();
        configure('0, 25'd1, 1'b1);
        send_sample(5, 1'b1);
        send_sample(6, 1'b1);
        configure('0, 25'd4, 1'b0);
        send_sample(1, 1'b1);
        send_sample(-3, 1'b1);
        send_sample(7, 1'b1);
        send_sample(8, 1'b1);
    endtask

    // short last record of a group, truncation toward zero, shrunk final group
    task automatic test_group_shrink();
        configure(11'd3, 25'd6, 1'b0);
        send_sample(0, 1'b1);
        send_sample(-7, 1'b0);
        send_sample(VALUE_MAX, 1'b1);
        send_sample(-2, 1'b0);
        send_sample(VALUE_MAX, 1'b1);
        send_sample(-1, 1'b1);
        send_sample(100, 1'b0);
        send_sample(3, 1'b1);
        send_sample(9, 1'b1);
    endtask

    // largest record count, then lowered mid-dataset so the partial group is dropped
    task automatic test_count_lowered();
        configure(11'd2, {CNT_BITS{1'b1}}, 1'b0);
        send_sample(1, 1'b1);
        send_sample(10, 1'b1);
        configure(11'd2, 25'd2, 1'b0);
        send_sample(11, 1'b1);
    endtask

    task automatic test_random_datasets();
        int unsigned start;
        start = samples_sent;
        while (samples_sent - start < RANDOM_ITEMS) begin
            case ($urandom_range(0, 5))
                0: begin
                    configure(pick_group(), ($urandom_range(0, 1) == 0) ? {CNT_BITS{1'b1}} :
                              CNT_BITS'($urandom_range(1000, 33554431)), 1'b0);
                    repeat ($urandom_range(1, 5)) send_record(pick_len());
                    configure(cfg_group, CNT_BITS'($urandom_range(0, 3)),
                              $urandom_range(0, 3) == 0);
                    finish_dataset();
                end
                1: begin
                    configure(pick_group(), pick_count(), $urandom_range(0, 3) == 0);
                    repeat ($urandom_range(1, 3)) send_record(pick_len());
                    configure(pick_group(), cfg_count, 1'b0);
                    finish_dataset();
                end
                default: begin
                    configure(pick_group(), pick_count(), $urandom_range(0, 3) == 0);
                    do send_record(pick_len()); while (rec_pos != 0);
                end
            endcase
        end
    endtask

    // one group per record so every request yields a result while the output is held
    task automatic test_backpressure();
        configure(11'd1, 25'd5, 1'b0);
        tx_gaps = 1'b0;
        hold_reqs <= hold_reqs + 1;
        repeat (3) send_record(CHANNELS);
        finish_dataset();
        tx_gaps = 1'b1;
    endtask

    task automatic test_no_idling();
        int unsigned start;
        rx_idling <= 1'b0;
        tx_gaps = 1'b0;
        start = samples_sent;
        while (samples_sent - start < QUIET_ITEMS) begin
            configure(pick_group(), pick_count(), 1'b0);
            do send_record(pick_len()); while (rec_pos != 0);
        end
    endtask

    initial begin
        int waited;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_after_reset();
        test_degenerate_config();
        test_group_shrink();
        test_count_lowered();
        test_random_datasets();
        test_backpressure();
        test_no_idling();
        i_valid <= 1'b0;
        waited = 0;
        while (expected_means.size() != 0 && waited < DRAIN_LIMIT) begin
            @(negedge i_clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        if (expected_means.size() != 0) begin
            $display("%0d expected results never arrived", expected_means.size());
            failures += expected_means.size();
        end
        $display("covered %0d input requests, %0d output requests, %0d datasets, %0d writes",
                 samples_sent, results_seen, datasets_closed, cfg_writes);
        $display("group sizes 0 to 2047, counts 0 to full scale, short records, long hold-off");
        if (failures == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

@@ block_average_decimator.f @@
rtl/bavg_pkg.sv
rtl/bavg_sum_ram.sv
rtl/bavg_div.sv
rtl/block_average_decimator.sv
verif/tb_block_average_decimator.sv
